// ----- hdl/pls_pkg.sv -----
// Shared types and codes for the positional list store.
`default_nettype none

package pls_pkg;

  localparam int unsigned POS_W    = 5;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_GET    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Action broadcast to every cell for the request accepted this cycle
  typedef struct packed {
    logic ins;  // shift up from the position, write new element at it
    logic rem;  // shift down from the position
    logic rd;   // read the element at the position
  } op_t;

endpackage

`default_nettype wire

// ----- hdl/pls_cell.sv -----
// One storage cell of the shifting list: holds one element, trades with its neighbors.
`default_nettype none

module pls_cell #(
  parameter int unsigned W = 32
) (
  input  wire logic         clk,
  input  wire pls_pkg::op_t op,
  input  wire logic         at_pos,    // this cell sits at the requested position
  input  wire logic         past_pos,  // this cell sits above the requested position
  input  wire logic [W-1:0] left_d,    // element of the cell one position lower
  input  wire logic [W-1:0] right_d,   // element of the cell one position higher
  input  wire logic [W-1:0] new_d,
  output logic      [W-1:0] data_q,
  output logic      [W-1:0] hit_d      // own element when addressed, else zero
);

  logic [W-1:0] data_r;
  logic [W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (op.ins && past_pos) begin
      data_nxt = left_d;
    end else if (op.ins && at_pos) begin
      data_nxt = new_d;
    end else if (op.rem && (at_pos || past_pos)) begin
      data_nxt = right_d;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;
  assign hit_d  = at_pos ? data_r : '0;

endmodule

`default_nettype wire

// ----- hdl/pls_ctrl.sv -----
// Command decode, status checks and element count for the positional list store.
`default_nettype none

module pls_ctrl #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         accept,
  input  wire pls_pkg::cmd_t                cmd,
  input  wire logic [pls_pkg::POS_W-1:0]    pos,
  output pls_pkg::op_t                      op,
  output pls_pkg::status_t                  status,
  output logic      [$clog2(DEPTH+1)-1:0]   count_after,
  output logic      [DEPTH-1:0]             at_pos,
  output logic      [DEPTH-1:0]             past_pos
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > pls_pkg::POS_W) ? CNT_W : pls_pkg::POS_W;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             is_full;
  logic             is_empty;

  assign pos_x    = CMP_W'(pos);
  assign cnt_x    = CMP_W'(count_r);
  assign is_full  = (count_r == CNT_W'(DEPTH));
  assign is_empty = (count_r == '0);

  // position decode, an equality and a less-than compare per cell
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      at_pos[i]   = (pos_x == CMP_W'(i));
      past_pos[i] = (pos_x <  CMP_W'(i));
    end
  end

  always_comb begin
    status = pls_pkg::ST_OK;
    op     = '0;
    case (cmd)
      pls_pkg::CMD_INSERT: begin
        if (is_full) begin
          status = pls_pkg::ST_FULL;
        end else if (pos_x > cnt_x) begin
          status = pls_pkg::ST_BADPOS;
        end else begin
          op.ins = accept;
        end
      end
      pls_pkg::CMD_GET: begin
        if (is_empty) begin
          status = pls_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status = pls_pkg::ST_BADPOS;
        end else begin
          op.rd = accept;
        end
      end
      pls_pkg::CMD_REMOVE: begin
        if (is_empty) begin
          status = pls_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          status = pls_pkg::ST_BADPOS;
        end else begin
          op.rem = accept;
        end
      end
      pls_pkg::CMD_CLEAR: begin
        status = pls_pkg::ST_OK;
      end
      default: begin
        status = pls_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    count_after = count_r;
    if (op.ins) begin
      count_after = count_r + 1'b1;
    end else if (op.rem) begin
      count_after = count_r - 1'b1;
    end else if (cmd == pls_pkg::CMD_CLEAR) begin
      count_after = '0;
    end
  end

  assign count_nxt = accept ? count_after : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("element count above depth");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({op.ins, op.rem, op.rd}))
    else $error("more than one cell action at once");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    op.ins |=> count_r == CNT_W'($past(count_r) + 1'b1))
    else $error("insert did not grow the count");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && cmd == pls_pkg::CMD_CLEAR) |=> is_empty)
    else $error("clear left elements behind");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("count moved without a request");

endmodule

`default_nettype wire

// ----- hdl/positional_list_store_top.sv -----
// Positional list store: a row of shifting cells with insert, get, remove and clear.
// Takes one request per clock while in_tready is high and returns one result per request,
// in the cycle after it is accepted. Each request is decoded against the element count
// combinationally and every cell of the row moves at once (insert shifts the cells above
// the position up, remove shifts them down), so the row never stalls; in_tready drops only
// while the registered result waits and out_tready is low. DEPTH sets the number of cells,
// ELEM_WIDTH the stored element width (elements are kept to at most 32 bits, as wide
// as the data field). Elements come back zero-extended on out_tdata.
`default_nettype none

module positional_list_store_top #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [4:0] position, [36:5] elem_value, rest zero
  input  wire logic [1:0]  in_tuser,   // [1:0] cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [39:0] out_tdata,  // [31:0] elem_out, [36:32] count_now, rest zero
  output logic      [1:0]  out_tuser   // [1:0] status
);

  localparam int unsigned SW    = (ELEM_WIDTH < pls_pkg::VAL_W) ? ELEM_WIDTH : pls_pkg::VAL_W;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned POS_LSB = 0;
  localparam int unsigned VAL_LSB = pls_pkg::POS_W;

  logic                         accept;
  pls_pkg::cmd_t                cmd;
  logic [pls_pkg::POS_W-1:0]    pos;
  logic [SW-1:0]                elem_in;
  pls_pkg::op_t                 op;
  pls_pkg::status_t             status;
  logic [CNT_W-1:0]             count_after;
  logic [DEPTH-1:0]             at_pos;
  logic [DEPTH-1:0]             past_pos;
  logic [SW-1:0]                cell_q [DEPTH];
  logic [SW-1:0]                hit_d  [DEPTH];
  logic [SW-1:0]                rd_data;

  logic                         out_valid_r;
  logic                         out_valid_nxt;
  pls_pkg::status_t             status_r;
  logic [pls_pkg::VAL_W-1:0]    elem_r;
  logic [pls_pkg::COUNT_W-1:0]  count_now_r;

  assign cmd     = pls_pkg::cmd_t'(in_tuser);
  assign pos     = in_tdata[POS_LSB +: pls_pkg::POS_W];
  assign elem_in = in_tdata[VAL_LSB +: SW];

  // accept while the result register is free or drains this cycle
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  pls_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .cmd        (cmd),
    .pos        (pos),
    .op         (op),
    .status     (status),
    .count_after(count_after),
    .at_pos     (at_pos),
    .past_pos   (past_pos)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [SW-1:0] left_d;
    logic [SW-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = elem_in;
    end else begin : g_mid_lo
      assign left_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_mid_hi
      assign right_d = cell_q[i+1];
    end

    pls_cell #(
      .W(SW)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .at_pos  (at_pos[i]),
      .past_pos(past_pos[i]),
      .left_d  (left_d),
      .right_d (right_d),
      .new_d   (elem_in),
      .data_q  (cell_q[i]),
      .hit_d   (hit_d[i])
    );
  end

  // only the addressed cell drives a nonzero hit
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | hit_d[i];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status;
      elem_r      <= op.rd ? pls_pkg::VAL_W'(rd_data) : '0;
      count_now_r <= pls_pkg::COUNT_W'(count_after);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = {3'b000, count_now_r, elem_r};

endmodule

`default_nettype wire
